>>> hw/rtl/fbvt_pkg.sv
// Package for the frustum versus box visibility test.
// Holds opcodes, result codes, table sizes and the sequencer state type.
// No dependencies.
`default_nettype none

package fbvt_pkg;

   // Number format defaults (signed fixed point)
   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;

   // Table geometry
   localparam int NUM_PLANES   = 6;
   localparam int NUM_CORNERS  = 8;
   localparam int TABLE_DEPTH  = 24;
   localparam int INDEX_WIDTH  = 5;

   // Request opcodes
   localparam logic [1:0] OP_LOAD_PLANE  = 2'd0;
   localparam logic [1:0] OP_LOAD_CORNER = 2'd1;
   localparam logic [1:0] OP_TEST_BOX    = 2'd2;

   // Visibility codes
   localparam logic [1:0] VIS_NONE    = 2'd0;
   localparam logic [1:0] VIS_PARTIAL = 2'd1;
   localparam logic [1:0] VIS_FULL    = 2'd2;

   // Coefficient slot of the plane offset
   localparam logic [1:0] COEF_D = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH,
      S_MLO,
      S_MHI,
      S_ACC,
      S_DCHK,
      S_CFETCH,
      S_CCMP
   } state_type;

endpackage

`default_nettype wire

>>> hw/rtl/fbvt_req_if.sv
// Request channel of the visibility test: valid/ready plus one request word.
// Depends on fbvt_pkg.
`default_nettype none

interface fbvt_req_if
   import fbvt_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic [1:0]                    op;
   logic [INDEX_WIDTH-1:0]        table_index;
   logic signed [COORD_WIDTH-1:0] load_value;
   logic signed [COORD_WIDTH-1:0] box_min_x;
   logic signed [COORD_WIDTH-1:0] box_min_y;
   logic signed [COORD_WIDTH-1:0] box_min_z;
   logic signed [COORD_WIDTH-1:0] box_max_x;
   logic signed [COORD_WIDTH-1:0] box_max_y;
   logic signed [COORD_WIDTH-1:0] box_max_z;

   modport source (
      output valid, op, table_index, load_value,
             box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
      input  ready
   );
   modport sink (
      input  valid, op, table_index, load_value,
             box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
      output ready
   );
endinterface

`default_nettype wire

>>> hw/rtl/fbvt_rsp_if.sv
// Response channel of the visibility test: valid/ready plus the visibility code.
// Depends on fbvt_pkg only by convention.
`default_nettype none

interface fbvt_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] visibility;

   modport source (output valid, visibility, input ready);
   modport sink   (input valid, visibility, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/frustum_box_visibility_test.sv
// Top level of the frustum versus axis-aligned box visibility test.
// Depends on fbvt_pkg, fbvt_req_if and fbvt_rsp_if.
//
//   channel   dir   word contents
//   req_chan  in    op, table_index, load_value, box min/max x,y,z
//   rsp_chan  out   visibility (0 none, 1 partial, 2 full)
//
// Load words are written when accepted. A test word evaluates each plane in
// turn (3 coefficients, each times the low and high bound, then fetch and
// check of the offset) and may then run a corner pass over the box axes.
// Cost is set by the one shared COORD_WIDTH x COORD_WIDTH multiplier and the
// single read port of each table. Reset is synchronous and clears control
// state only; the tables are undefined until loaded. A waiting response word
// blocks new requests until it is taken.
`default_nettype none

module frustum_box_visibility_test
   import fbvt_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   fbvt_req_if.sink     req_chan,
   fbvt_rsp_if.source   rsp_chan
);

   localparam int W     = COORD_WIDTH;
   localparam int PW    = 2 * W;
   localparam int ACC_W = 2 * W + 2;

   // Control registers
   state_type state_ff, state_in;
   logic [1:0] coef_ff, coef_in;
   logic [2:0] plane_ff, plane_in;
   logic [2:0] inside_ff, inside_in;
   logic [1:0] axis_ff, axis_in;
   logic [2:0] corner_ff, corner_in;
   logic       above_ff, above_in;
   logic       below_ff, below_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic [1:0]              vis_ff, vis_in;
   logic signed [W-1:0]     lo_x_ff, lo_y_ff, lo_z_ff;
   logic signed [W-1:0]     hi_x_ff, hi_y_ff, hi_z_ff;
   logic signed [PW-1:0]    prod_lo_ff, prod_lo_in;
   logic signed [PW-1:0]    prod_hi_ff, prod_hi_in;
   logic signed [ACC_W-1:0] min_acc_ff, min_acc_in;
   logic signed [ACC_W-1:0] max_acc_ff, max_acc_in;

   // Tables
   logic signed [W-1:0] plane_mem [TABLE_DEPTH];
   logic signed [W-1:0] corner_mem [TABLE_DEPTH];
   logic signed [W-1:0] plane_rd_ff;
   logic signed [W-1:0] corner_rd_ff;

   logic                   req_accept;
   logic                   start_test;
   logic                   idx_ok;
   logic [INDEX_WIDTH-1:0] plane_addr;
   logic [INDEX_WIDTH-1:0] corner_addr;
   logic signed [W-1:0]    lo_sel, hi_sel, mul_b;
   logic signed [PW-1:0]   mul_p;
   logic signed [PW-1:0]   p_small, p_big;
   logic signed [ACC_W-1:0] d_aligned, min_sum, max_sum;
   logic signed [W-1:0]    ax_lo, ax_hi;
   logic                   above_now, below_now;
   logic [2:0]             inside_next;

   assign req_chan.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign start_test     = req_accept && (req_chan.op == OP_TEST_BOX);
   assign idx_ok         = req_chan.table_index < INDEX_WIDTH'(TABLE_DEPTH);

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.visibility = vis_ff;

   // Table addresses from the counters
   assign plane_addr  = {plane_ff[2:0], coef_ff};
   assign corner_addr = (INDEX_WIDTH'(corner_ff) << 1) + INDEX_WIDTH'(corner_ff)
                        + INDEX_WIDTH'(axis_ff);

   // Load writes and registered table reads
   always_ff @(posedge clock) begin
      if (req_accept && idx_ok && req_chan.op == OP_LOAD_PLANE) begin
         plane_mem[req_chan.table_index] <= req_chan.load_value;
      end
      if (req_accept && idx_ok && req_chan.op == OP_LOAD_CORNER) begin
         corner_mem[req_chan.table_index] <= req_chan.load_value;
      end
      if (state_ff == S_FETCH) begin
         plane_rd_ff <= plane_mem[plane_addr];
      end
      if (state_ff == S_CFETCH) begin
         corner_rd_ff <= corner_mem[corner_addr];
      end
   end

   // Select the box bounds for the current coefficient and axis
   always_comb begin
      case (coef_ff)
         2'd1:    begin lo_sel = lo_y_ff; hi_sel = hi_y_ff; end
         2'd2:    begin lo_sel = lo_z_ff; hi_sel = hi_z_ff; end
         default: begin lo_sel = lo_x_ff; hi_sel = hi_x_ff; end
      endcase
      case (axis_ff)
         2'd1:    begin ax_lo = lo_y_ff; ax_hi = hi_y_ff; end
         2'd2:    begin ax_lo = lo_z_ff; ax_hi = hi_z_ff; end
         default: begin ax_lo = lo_x_ff; ax_hi = hi_x_ff; end
      endcase
   end

   // Shared multiplier: coefficient times low or high bound
   assign mul_b = (state_ff == S_MHI) ? hi_sel : lo_sel;
   assign mul_p = plane_rd_ff * mul_b;

   // Smaller and larger product of one coefficient
   assign p_small = (prod_lo_ff < prod_hi_ff) ? prod_lo_ff : prod_hi_ff;
   assign p_big   = (prod_lo_ff < prod_hi_ff) ? prod_hi_ff : prod_lo_ff;

   // Offset aligned to the product fraction, added to both extremes
   assign d_aligned = ACC_W'(plane_rd_ff) <<< FRAC_BITS;
   assign min_sum   = min_acc_ff + d_aligned;
   assign max_sum   = max_acc_ff + d_aligned;
   assign inside_next = inside_ff + {2'b00, ~min_sum[ACC_W-1]};

   // Corner against the current box slab
   assign above_now = corner_rd_ff > ax_hi;
   assign below_now = corner_rd_ff < ax_lo;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (start_test) state_in = S_FETCH;
         S_FETCH:  state_in = (coef_ff == COEF_D) ? S_DCHK : S_MLO;
         S_MLO:    state_in = S_MHI;
         S_MHI:    state_in = S_ACC;
         S_ACC:    state_in = S_FETCH;
         S_DCHK: begin
            if (max_sum[ACC_W-1]) begin
               state_in = S_IDLE;
            end else if (plane_ff == 3'(NUM_PLANES - 1)) begin
               state_in = (inside_next == 3'(NUM_PLANES)) ? S_IDLE : S_CFETCH;
            end else begin
               state_in = S_FETCH;
            end
         end
         S_CFETCH: state_in = S_CCMP;
         S_CCMP: begin
            if (corner_ff == 3'(NUM_CORNERS - 1)) begin
               if ((above_ff && above_now) || (below_ff && below_now) || axis_ff == 2'd2) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_CFETCH;
               end
            end else begin
               state_in = S_CFETCH;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // Datapath and response updates
   always_comb begin
      coef_in      = coef_ff;
      plane_in     = plane_ff;
      inside_in    = inside_ff;
      axis_in      = axis_ff;
      corner_in    = corner_ff;
      above_in     = above_ff;
      below_in     = below_ff;
      prod_lo_in   = prod_lo_ff;
      prod_hi_in   = prod_hi_ff;
      min_acc_in   = min_acc_ff;
      max_acc_in   = max_acc_ff;
      vis_in       = vis_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      unique case (state_ff)
         S_IDLE: begin
            coef_in    = '0;
            plane_in   = '0;
            inside_in  = '0;
            min_acc_in = '0;
            max_acc_in = '0;
         end
         S_FETCH: ;
         S_MLO: prod_lo_in = mul_p;
         S_MHI: prod_hi_in = mul_p;
         S_ACC: begin
            min_acc_in = min_acc_ff + ACC_W'(p_small);
            max_acc_in = max_acc_ff + ACC_W'(p_big);
            coef_in    = coef_ff + 2'd1;
         end
         S_DCHK: begin
            inside_in  = inside_next;
            coef_in    = '0;
            plane_in   = plane_ff + 3'd1;
            min_acc_in = '0;
            max_acc_in = '0;
            axis_in    = '0;
            corner_in  = '0;
            above_in   = 1'b1;
            below_in   = 1'b1;
            if (max_sum[ACC_W-1]) begin
               rsp_valid_in = 1'b1;
               vis_in       = VIS_NONE;
            end else if (plane_ff == 3'(NUM_PLANES - 1) && inside_next == 3'(NUM_PLANES)) begin
               rsp_valid_in = 1'b1;
               vis_in       = VIS_FULL;
            end
         end
         S_CFETCH: ;
         S_CCMP: begin
            above_in  = above_ff && above_now;
            below_in  = below_ff && below_now;
            corner_in = corner_ff + 3'd1;
            if (corner_ff == 3'(NUM_CORNERS - 1)) begin
               if ((above_ff && above_now) || (below_ff && below_now)) begin
                  rsp_valid_in = 1'b1;
                  vis_in       = VIS_NONE;
               end else if (axis_ff == 2'd2) begin
                  rsp_valid_in = 1'b1;
                  vis_in       = VIS_PARTIAL;
               end else begin
                  axis_in  = axis_ff + 2'd1;
                  above_in = 1'b1;
                  below_in = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         coef_ff      <= '0;
         plane_ff     <= '0;
         inside_ff    <= '0;
         axis_ff      <= '0;
         corner_ff    <= '0;
         above_ff     <= 1'b0;
         below_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         coef_ff      <= coef_in;
         plane_ff     <= plane_in;
         inside_ff    <= inside_in;
         axis_ff      <= axis_in;
         corner_ff    <= corner_in;
         above_ff     <= above_in;
         below_ff     <= below_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      prod_lo_ff <= prod_lo_in;
      prod_hi_ff <= prod_hi_in;
      min_acc_ff <= min_acc_in;
      max_acc_ff <= max_acc_in;
      vis_ff     <= vis_in;
      if (start_test) begin
         lo_x_ff <= req_chan.box_min_x;
         lo_y_ff <= req_chan.box_min_y;
         lo_z_ff <= req_chan.box_min_z;
         hi_x_ff <= req_chan.box_max_x;
         hi_y_ff <= req_chan.box_max_y;
         hi_z_ff <= req_chan.box_max_z;
      end
   end

   // Checks
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_chan.ready)
      else $error("request taken while a test is running");

   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DCHK || $past(state_ff) == S_CCMP))
      else $error("response raised outside a decision step");

   a_inside_bound: assert property (@(posedge clock) disable iff (reset)
      inside_ff <= 3'(NUM_PLANES))
      else $error("inside count exceeds plane count");

   a_vis_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (vis_ff == VIS_NONE || vis_ff == VIS_PARTIAL || vis_ff == VIS_FULL))
      else $error("illegal visibility code");

endmodule

`default_nettype wire
